/* sv/ubce_pkg.sv */
// Package for the serial boot-loader command engine.
// Holds protocol bytes, memory operation codes, configuration indices and the result item struct.
// No dependencies.
`timescale 1ns / 1ps
package ubce_pkg;

  localparam logic [7:0] ACK_BYTE  = 8'h79;
  localparam logic [7:0] NACK_BYTE = 8'h1F;
  localparam logic [7:0] SYNC_BYTE = 8'h7F;
  localparam logic [7:0] CMD_GET   = 8'h00;
  localparam logic [7:0] CMD_GETID = 8'h02;
  localparam logic [7:0] CMD_RDMEM = 8'h11;
  localparam logic [7:0] CMD_GO    = 8'h21;
  localparam logic [7:0] CMD_WRMEM = 8'h31;
  localparam logic [7:0] CMD_ERASE = 8'h44;
  localparam logic [7:0] CMD_NONE  = 8'hFF;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_READ  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_ERASE = 3'd3;
  localparam logic [2:0] OP_JUMP  = 3'd4;

  localparam logic [2:0] CFG_FLASH_BASE = 3'd0;
  localparam logic [2:0] CFG_RAM_BASE   = 3'd1;
  localparam logic [2:0] CFG_BOOT_SIZE  = 3'd2;
  localparam logic [2:0] CFG_CHIP_ID    = 3'd3;
  localparam logic [2:0] CFG_VERSION    = 3'd4;

  // One result item as presented on the output.
  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic [2:0] mem_op;
    logic [31:0] mem_addr;
    logic [31:0] mem_data;
    logic       to_flash;
    logic       last;
  } result_t;

endpackage

/* sv/ubce_datapath.sv */
// Datapath of the boot-loader engine: field registers, checksum, word buffer
// and the write-walk address unit. Has no package dependencies.
`timescale 1ns / 1ps
module ubce_datapath #(
  parameter int BUFFER_WORDS = 64,
  parameter int WIDX = 6
) (
  input  logic        clk,
  input  logic [7:0]  rx_byte,
  input  logic        ld_cmd,     // latch command byte
  input  logic        clr_addr,   // clear address and counter
  input  logic        sh_addr,    // shift a byte into the address
  input  logic        sh_erase,   // shift a byte into the 16-bit page count
  input  logic        ld_len,     // latch length byte
  input  logic        st_data,    // store a data byte
  input  logic        walk_start, // begin the word walk
  input  logic        walk_step,  // advance the word walk
  input  logic [31:0] flash_base,
  input  logic [31:0] ram_base,
  input  logic [20:0] boot_size,
  output logic [7:0]  command,
  output logic [31:0] address,
  output logic [8:0]  byte_count,
  output logic [7:0]  len_m1,
  output logic [7:0]  running_xor,
  output logic        addr_chk_ok,
  output logic [31:0] walk_addr,
  output logic [31:0] walk_word,
  output logic [6:0]  walk_idx,
  output logic        walk_skip,
  output logic        in_flash
);

  logic [7:0]  command_r;
  logic [31:0] address_r;
  logic [8:0]  byte_count_r;
  logic [7:0]  len_m1_r, xor_r;
  logic [6:0]  walk_idx_r;
  logic [31:0] walk_addr_r;
  logic [31:0] buf_mem [BUFFER_WORDS];
  logic [31:0] word_q;
  logic [WIDX-1:0] wr_idx, rd_idx;
  logic [32:0] prot_end;

  assign wr_idx = byte_count_r[WIDX+1:2];
  assign rd_idx = walk_idx_r[WIDX-1:0];

  // Field registers and checksum.
  always_ff @(posedge clk) begin
    if (ld_cmd) command_r <= rx_byte;
    if (clr_addr) begin
      address_r    <= '0;
      byte_count_r <= '0;
    end else if (sh_addr) begin
      address_r    <= {address_r[23:0], rx_byte};
      byte_count_r <= byte_count_r + 9'd1;
    end else if (sh_erase) begin
      address_r    <= {16'd0, address_r[7:0], rx_byte};
      byte_count_r <= byte_count_r + 9'd1;
    end else if (ld_len) begin
      byte_count_r <= '0;
    end else if (st_data) begin
      byte_count_r <= byte_count_r + 9'd1;
    end
    if (ld_len) begin
      len_m1_r <= rx_byte;
      xor_r    <= rx_byte;
    end else if (st_data) begin
      xor_r <= xor_r ^ rx_byte;
    end
  end

  // Word buffer: one byte lane written per data byte, one word read per cycle.
  always_ff @(posedge clk) begin
    if (st_data && (byte_count_r[8:2] < 7'(BUFFER_WORDS))) begin
      case (byte_count_r[1:0])
        2'd0: buf_mem[wr_idx] <= {24'd0, rx_byte};
        2'd1: buf_mem[wr_idx][15:8] <= rx_byte;
        2'd2: buf_mem[wr_idx][23:16] <= rx_byte;
        default: buf_mem[wr_idx][31:24] <= rx_byte;
      endcase
    end
    word_q <= buf_mem[rd_idx];
  end

  // Word walk: index and address advance together; read data is registered and arrives in the cycle after the index.
  always_ff @(posedge clk) begin
    if (walk_start) begin
      walk_idx_r  <= '0;
      walk_addr_r <= address_r;
    end else if (walk_step) begin
      walk_idx_r  <= walk_idx_r + 7'd1;
      walk_addr_r <= walk_addr_r + 32'd4;
    end
  end

  assign prot_end    = {1'b0, flash_base} + {12'd0, boot_size};
  assign in_flash    = (address_r >= flash_base) && (address_r < ram_base);
  assign walk_skip   = in_flash && ({1'b0, walk_addr_r} < prot_end);
  assign addr_chk_ok = (address_r[7:0] ^ address_r[15:8] ^ address_r[23:16]
                        ^ address_r[31:24]) == rx_byte;
  assign command     = command_r;
  assign address     = address_r;
  assign byte_count  = byte_count_r;
  assign len_m1      = len_m1_r;
  assign running_xor = xor_r;
  assign walk_addr   = walk_addr_r;
  assign walk_word   = word_q;
  assign walk_idx    = walk_idx_r;

endmodule

/* sv/ubce_ctrl.sv */
// Controller of the boot-loader engine: protocol phases, reply sequencing
// and the write walk. Depends on ubce_pkg.
`timescale 1ns / 1ps
module ubce_ctrl #(
  parameter int BUFFER_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_ready,
  output ubce_pkg::result_t res,
  output logic        ld_cmd,
  output logic        clr_addr,
  output logic        sh_addr,
  output logic        sh_erase,
  output logic        ld_len,
  output logic        st_data,
  output logic        walk_start,
  output logic        walk_step,
  input  logic [7:0]  command,
  input  logic [31:0] address,
  input  logic [8:0]  byte_count,
  input  logic [7:0]  len_m1,
  input  logic [7:0]  running_xor,
  input  logic        addr_chk_ok,
  input  logic [31:0] walk_addr,
  input  logic [31:0] walk_word,
  input  logic [6:0]  walk_idx,
  input  logic        walk_skip,
  input  logic        in_flash,
  input  logic [31:0] flash_base,
  input  logic [20:0] boot_size,
  input  logic [15:0] chip_id,
  input  logic [7:0]  version_byte
);

  // Protocol phases.
  localparam logic [3:0] PH_UNSYNCED  = 4'd0;
  localparam logic [3:0] PH_IDLE      = 4'd1;
  localparam logic [3:0] PH_COMPL     = 4'd2;
  localparam logic [3:0] PH_ADDR      = 4'd3;
  localparam logic [3:0] PH_ADDR_CHK  = 4'd4;
  localparam logic [3:0] PH_LEN       = 4'd5;
  localparam logic [3:0] PH_READ_CHK  = 4'd6;
  localparam logic [3:0] PH_DATA      = 4'd7;
  localparam logic [3:0] PH_DATA_CHK  = 4'd8;
  localparam logic [3:0] PH_ERASE_N   = 4'd9;
  localparam logic [3:0] PH_ERASE_CHK = 4'd10;

  // Emission modes.
  localparam logic [2:0] EM_NONE  = 3'd0;
  localparam logic [2:0] EM_LIST  = 3'd1; // fixed byte list (get / get-id)
  localparam logic [2:0] EM_WALK  = 3'd2; // waiting for the buffer read of the next word
  localparam logic [2:0] EM_WALKV = 3'd3; // walking, buffer data valid
  localparam logic [2:0] EM_ONE   = 3'd4; // one pending item in hold

  logic [3:0] phase_r, phase_nxt;
  logic [2:0] mode_r, mode_nxt;
  logic [3:0] lidx_r, lidx_nxt;
  logic       lget_r, lget_nxt;
  logic [6:0] nwords_r, nwords_nxt;
  logic       ovalid_r, ovalid_nxt;
  ubce_pkg::result_t out_r, out_nxt, hold_r, hold_nxt;
  logic       hvalid_r, hvalid_nxt;
  logic       take;
  logic       oslot;
  logic [7:0] lbyte;
  logic [3:0] lcount;
  logic [8:0] cnt;

  assign oslot    = !ovalid_r || res_ready;
  assign in_ready = (mode_r == EM_NONE) && !hvalid_r && oslot;
  assign take     = in_valid && in_ready;
  assign cnt      = {1'b0, len_m1} + 9'd1;
  assign res_valid = ovalid_r;
  assign res       = out_r;

  function automatic ubce_pkg::result_t mk_send(input logic [7:0] b, input logic lst);
    ubce_pkg::result_t r;
    r = '0;
    r.send_valid = 1'b1;
    r.send_byte  = b;
    r.last       = lst;
    return r;
  endfunction

  // Byte list of the get and get-id replies.
  always_comb begin
    lcount = lget_r ? 4'd10 : 4'd5;
    lbyte  = ubce_pkg::ACK_BYTE;
    if (lget_r) begin
      case (lidx_r)
        4'd0: lbyte = ubce_pkg::ACK_BYTE;
        4'd1: lbyte = 8'd6;
        4'd2: lbyte = version_byte;
        4'd3: lbyte = ubce_pkg::CMD_GET;
        4'd4: lbyte = ubce_pkg::CMD_GETID;
        4'd5: lbyte = ubce_pkg::CMD_RDMEM;
        4'd6: lbyte = ubce_pkg::CMD_GO;
        4'd7: lbyte = ubce_pkg::CMD_WRMEM;
        4'd8: lbyte = ubce_pkg::CMD_ERASE;
        default: lbyte = ubce_pkg::ACK_BYTE;
      endcase
    end else begin
      case (lidx_r)
        4'd0: lbyte = ubce_pkg::ACK_BYTE;
        4'd1: lbyte = 8'd1;
        4'd2: lbyte = chip_id[15:8];
        4'd3: lbyte = chip_id[7:0];
        default: lbyte = ubce_pkg::ACK_BYTE;
      endcase
    end
  end

  // Phase machine and result sequencing.
  always_comb begin
    phase_nxt  = phase_r;
    mode_nxt   = mode_r;
    lidx_nxt   = lidx_r;
    lget_nxt   = lget_r;
    nwords_nxt = nwords_r;
    hold_nxt   = hold_r;
    hvalid_nxt = hvalid_r;
    out_nxt    = out_r;
    ovalid_nxt = ovalid_r && !res_ready;
    ld_cmd = 1'b0; clr_addr = 1'b0; sh_addr = 1'b0; sh_erase = 1'b0;
    ld_len = 1'b0; st_data = 1'b0; walk_start = 1'b0; walk_step = 1'b0;

    if (take) begin
      case (phase_r)
        PH_UNSYNCED: begin
          if (rx_byte == ubce_pkg::SYNC_BYTE) begin
            out_nxt = mk_send(ubce_pkg::ACK_BYTE, 1'b1);
            ovalid_nxt = 1'b1;
            phase_nxt = PH_IDLE;
          end
        end
        PH_IDLE: begin
          ld_cmd = 1'b1;
          phase_nxt = (rx_byte != ubce_pkg::CMD_NONE) ? PH_COMPL : PH_IDLE;
        end
        PH_COMPL: begin
          phase_nxt = PH_IDLE;
          ovalid_nxt = 1'b1;
          out_nxt = mk_send(ubce_pkg::NACK_BYTE, 1'b1);
          if (rx_byte == ~command) begin
            case (command)
              ubce_pkg::CMD_GET, ubce_pkg::CMD_GETID: begin
                out_nxt = mk_send(ubce_pkg::ACK_BYTE, 1'b0);
                mode_nxt = EM_LIST;
                lidx_nxt = 4'd1;
                lget_nxt = (command == ubce_pkg::CMD_GET);
              end
              ubce_pkg::CMD_RDMEM, ubce_pkg::CMD_GO, ubce_pkg::CMD_WRMEM: begin
                out_nxt = mk_send(ubce_pkg::ACK_BYTE, 1'b1);
                clr_addr = 1'b1;
                phase_nxt = PH_ADDR;
              end
              ubce_pkg::CMD_ERASE: begin
                out_nxt = mk_send(ubce_pkg::ACK_BYTE, 1'b1);
                clr_addr = 1'b1;
                phase_nxt = PH_ERASE_N;
              end
              default: ;
            endcase
          end
        end
        PH_ADDR: begin
          sh_addr = 1'b1;
          if (byte_count >= 9'd3) phase_nxt = PH_ADDR_CHK;
        end
        PH_ADDR_CHK: begin
          phase_nxt = PH_IDLE;
          ovalid_nxt = 1'b1;
          if (command == ubce_pkg::CMD_WRMEM) begin
            if (addr_chk_ok) begin
              out_nxt = mk_send(ubce_pkg::ACK_BYTE, 1'b1);
              phase_nxt = PH_LEN;
            end else begin
              out_nxt = mk_send(ubce_pkg::NACK_BYTE, 1'b1);
            end
          end else if (command == ubce_pkg::CMD_RDMEM) begin
            out_nxt = mk_send(ubce_pkg::ACK_BYTE, 1'b1);
            phase_nxt = PH_LEN;
          end else begin
            out_nxt = mk_send(ubce_pkg::ACK_BYTE, 1'b0);
            hold_nxt = '0;
            hold_nxt.mem_op = ubce_pkg::OP_JUMP;
            hold_nxt.mem_addr = address;
            hold_nxt.last = 1'b1;
            hvalid_nxt = 1'b1;
            mode_nxt = EM_ONE;
          end
        end
        PH_LEN: begin
          ld_len = 1'b1;
          phase_nxt = (command == ubce_pkg::CMD_WRMEM) ? PH_DATA : PH_READ_CHK;
        end
        PH_READ_CHK: begin
          phase_nxt = PH_IDLE;
          ovalid_nxt = 1'b1;
          out_nxt = mk_send(ubce_pkg::ACK_BYTE, 1'b0);
          hold_nxt = '0;
          hold_nxt.mem_op = ubce_pkg::OP_READ;
          hold_nxt.mem_addr = address;
          hold_nxt.mem_data = {23'd0, cnt};
          hold_nxt.last = 1'b1;
          hvalid_nxt = 1'b1;
          mode_nxt = EM_ONE;
        end
        PH_DATA: begin
          st_data = 1'b1;
          if (byte_count + 9'd1 >= cnt) phase_nxt = PH_DATA_CHK;
        end
        PH_DATA_CHK: begin
          phase_nxt = PH_IDLE;
          if (rx_byte != running_xor || cnt[1:0] != 2'd0
              || cnt > 9'(4 * BUFFER_WORDS)) begin
            out_nxt = mk_send(ubce_pkg::NACK_BYTE, 1'b1);
            ovalid_nxt = 1'b1;
          end else begin
            walk_start = 1'b1;
            nwords_nxt = cnt[8:2];
            hvalid_nxt = 1'b0;
            mode_nxt = EM_WALK;
          end
        end
        PH_ERASE_N: begin
          sh_erase = 1'b1;
          if (byte_count >= 9'd1) phase_nxt = PH_ERASE_CHK;
        end
        PH_ERASE_CHK: begin
          phase_nxt = PH_IDLE;
          ovalid_nxt = 1'b1;
          if (address[15:0] == 16'hFFFF) begin
            out_nxt = '0;
            out_nxt.mem_op = ubce_pkg::OP_ERASE;
            out_nxt.mem_addr = flash_base + {11'd0, boot_size};
            hold_nxt = mk_send(ubce_pkg::ACK_BYTE, 1'b1);
            hvalid_nxt = 1'b1;
            mode_nxt = EM_ONE;
          end else begin
            out_nxt = mk_send(ubce_pkg::NACK_BYTE, 1'b1);
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end else begin
      case (mode_r)
        EM_LIST: begin
          if (oslot) begin
            out_nxt = mk_send(lbyte, lidx_r == lcount - 4'd1);
            ovalid_nxt = 1'b1;
            lidx_nxt = lidx_r + 4'd1;
            if (lidx_r == lcount - 4'd1) mode_nxt = EM_NONE;
          end
        end
        EM_ONE: begin
          if (oslot) begin
            out_nxt = hold_r;
            ovalid_nxt = 1'b1;
            hvalid_nxt = 1'b0;
            mode_nxt = EM_NONE;
          end
        end
        EM_WALK: mode_nxt = EM_WALKV;  // buffer read latency
        EM_WALKV: begin
          // Pending word in hold goes out once a following word or the end is known.
          if (walk_idx == nwords_r) begin
            if (oslot) begin
              if (hvalid_r) begin
                out_nxt = hold_r;
                out_nxt.send_valid = 1'b1;
                out_nxt.send_byte = ubce_pkg::ACK_BYTE;
                out_nxt.last = 1'b1;
              end else begin
                out_nxt = mk_send(ubce_pkg::ACK_BYTE, 1'b1);
              end
              ovalid_nxt = 1'b1;
              hvalid_nxt = 1'b0;
              mode_nxt = EM_NONE;
            end
          end else if (walk_skip) begin
            walk_step = 1'b1;
            mode_nxt = EM_WALK;
          end else if (!hvalid_r || oslot) begin
            if (hvalid_r) begin
              out_nxt = hold_r;
              ovalid_nxt = 1'b1;
            end
            hold_nxt = '0;
            hold_nxt.mem_op = ubce_pkg::OP_WRITE;
            hold_nxt.mem_addr = walk_addr;
            hold_nxt.mem_data = walk_word;
            hold_nxt.to_flash = in_flash;
            hvalid_nxt = 1'b1;
            walk_step = 1'b1;
            mode_nxt = EM_WALK;
          end
        end
        default: ;
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_UNSYNCED;
      mode_r   <= EM_NONE;
      ovalid_r <= 1'b0;
      hvalid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      mode_r   <= mode_nxt;
      ovalid_r <= ovalid_nxt;
      hvalid_r <= hvalid_nxt;
    end
    lidx_r   <= lidx_nxt;
    lget_r   <= lget_nxt;
    nwords_r <= nwords_nxt;
    hold_r   <= hold_nxt;
    out_r    <= out_nxt;
  end

endmodule

/* sv/uart_boot_command_engine_top.sv */
// Serial boot-loader command engine, one received byte per item. A byte's first
// result is registered and, except at a write finish, shows the cycle after it is
// taken; fixed replies give one item a cycle unless stalled. A write finish reads,
// then issues, each word. A new byte is taken once all results of the previous
// one have left the output register. Reset (rst_n, synchronous) returns to sync.
`timescale 1ns / 1ps
module uart_boot_command_engine_top #(
  parameter int BUFFER_WORDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_send_valid,
  output logic [7:0]  out_send_byte,
  output logic [2:0]  out_mem_op,
  output logic [31:0] out_mem_addr,
  output logic [31:0] out_mem_data,
  output logic        out_to_flash,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int WIDX = (BUFFER_WORDS > 1) ? $clog2(BUFFER_WORDS) : 1;

  logic [31:0] flash_base_r, ram_base_r;
  logic [20:0] boot_size_r;
  logic [15:0] chip_id_r;
  logic [7:0]  version_r;
  ubce_pkg::result_t res;
  logic ld_cmd, clr_addr, sh_addr, sh_erase, ld_len, st_data, walk_start, walk_step;
  logic [7:0] command, len_m1, running_xor;
  logic [31:0] address, walk_addr, walk_word;
  logic [8:0] byte_count;
  logic [6:0] walk_idx;
  logic addr_chk_ok, walk_skip, in_flash;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flash_base_r <= 32'h0800_0000;
      ram_base_r   <= 32'h2000_0000;
      boot_size_r  <= 21'd10240;
      chip_id_r    <= 16'h0414;
      version_r    <= 8'h30;
    end else if (cfg_we) begin
      case (cfg_index)
        ubce_pkg::CFG_FLASH_BASE: flash_base_r <= cfg_data;
        ubce_pkg::CFG_RAM_BASE:   ram_base_r   <= cfg_data;
        ubce_pkg::CFG_BOOT_SIZE:  boot_size_r  <= cfg_data[20:0];
        ubce_pkg::CFG_CHIP_ID:    chip_id_r    <= cfg_data[15:0];
        ubce_pkg::CFG_VERSION:    version_r    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  ubce_datapath #(.BUFFER_WORDS(BUFFER_WORDS), .WIDX(WIDX)) u_dp (
    .clk, .rx_byte(in_rx_byte), .ld_cmd, .clr_addr, .sh_addr, .sh_erase,
    .ld_len, .st_data, .walk_start, .walk_step,
    .flash_base(flash_base_r), .ram_base(ram_base_r), .boot_size(boot_size_r),
    .command, .address, .byte_count, .len_m1, .running_xor, .addr_chk_ok,
    .walk_addr, .walk_word, .walk_idx, .walk_skip, .in_flash
  );

  ubce_ctrl #(.BUFFER_WORDS(BUFFER_WORDS)) u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .rx_byte(in_rx_byte),
    .res_valid(out_valid), .res_ready(out_ready), .res,
    .ld_cmd, .clr_addr, .sh_addr, .sh_erase, .ld_len, .st_data,
    .walk_start, .walk_step, .command, .address, .byte_count, .len_m1,
    .running_xor, .addr_chk_ok, .walk_addr, .walk_word, .walk_idx,
    .walk_skip, .in_flash, .flash_base(flash_base_r), .boot_size(boot_size_r),
    .chip_id(chip_id_r), .version_byte(version_r)
  );

  assign out_send_valid = res.send_valid;
  assign out_send_byte  = res.send_byte;
  assign out_mem_op     = res.mem_op;
  assign out_mem_addr   = res.mem_addr;
  assign out_mem_data   = res.mem_data;
  assign out_to_flash   = res.to_flash;
  assign out_last       = res.last;

  // A new byte is never taken while a result is waiting unaccepted.
  a_no_take_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready) else $error("input taken during stall");

  // Only word writes may target flash.
  a_flash_only_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_to_flash) |-> (out_mem_op == ubce_pkg::OP_WRITE))
    else $error("to_flash on non-write");

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_mem_addr)
      && $stable(out_last))) else $error("result changed while stalled");

endmodule

/* tb/sv/uart_boot_command_engine_top_tb.sv */
// Self-checking testbench for the serial boot-loader command engine.
// A built-in predictor of the protocol state machine checks every result item
// against its expectation; it depends only on ubce_pkg and the top level.
`timescale 1ns / 1ps
module uart_boot_command_engine_top_tb;

  localparam int NWORDS = 64;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef enum logic [3:0] {
    PH_UNSYNCED, PH_IDLE, PH_COMPL, PH_ADDR, PH_ADDR_CHK, PH_LEN, PH_READ_CHK,
    PH_DATA, PH_DATA_CHK, PH_ERASE_N, PH_ERASE_CHK
  } boot_phase_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_rx_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_send_valid;
  logic [7:0] out_send_byte;
  logic [2:0] out_mem_op;
  logic [31:0] out_mem_addr;
  logic [31:0] out_mem_data;
  logic out_to_flash;
  logic out_last;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  uart_boot_command_engine_top i_dut (.*);

  // Clock: 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state and configuration copy.
  logic [31:0] flash_base_q, ram_base_q;
  logic [20:0] boot_size_q;
  logic [15:0] chip_id_q;
  logic [7:0] version_q;
  boot_phase_t phase_q;
  logic [7:0] cmd_q, len_m1_q, xor_q;
  logic [31:0] addr_q;
  logic [8:0] count_q;
  logic [31:0] words_q [NWORDS];

  ubce_pkg::result_t reply_queue[$];
  int mismatches = 0;
  int unexpected = 0;
  int results_seen = 0;
  int bytes_sent = 0;
  int sender_idle_pct = 0;
  int receiver_idle_pct = 0;
  int hold_off_cycles = 0;
  int idle_cycles = 0;
  int pred_count = 0;
  logic [7:0] pred_first = '0;
  bit timed_out = 1'b0;

  function automatic ubce_pkg::result_t mk(logic sv, logic [7:0] sb, logic [2:0] op,
                                           logic [31:0] a, logic [31:0] d, logic fl);
    ubce_pkg::result_t r;
    r.send_valid = sv; r.send_byte = sb; r.mem_op = op;
    r.mem_addr = a; r.mem_data = d; r.to_flash = fl; r.last = 1'b0;
    return r;
  endfunction

  task automatic push_byte(ref ubce_pkg::result_t q[$], input logic [7:0] b);
    q.push_back(mk(1'b1, b, ubce_pkg::OP_NONE, '0, '0, 1'b0));
  endtask

  // Close a write transfer: checksum and length checks, then word requests.
  task automatic finish_write(ref ubce_pkg::result_t q[$], input logic [7:0] chk);
    logic [31:0] cnt, real_addr;
    logic [32:0] protect_end;
    logic inflash;
    int issued;
    cnt = 32'(len_m1_q) + 1;
    issued = 0;
    if (chk != xor_q || cnt[1:0] != 2'b00 || cnt > 4 * NWORDS) begin
      push_byte(q, ubce_pkg::NACK_BYTE);
      return;
    end
    inflash = addr_q >= flash_base_q && addr_q < ram_base_q;
    protect_end = {1'b0, flash_base_q} + 33'(boot_size_q);
    for (int w = 0; w < cnt / 4; w++) begin
      real_addr = addr_q + 32'(4 * w);
      if (!(inflash && {1'b0, real_addr} < protect_end)) begin
        q.push_back(mk(1'b0, '0, ubce_pkg::OP_WRITE, real_addr, words_q[w], inflash));
        issued++;
      end
    end
    if (issued > 0) begin
      q[q.size()-1].send_valid = 1'b1;
      q[q.size()-1].send_byte = ubce_pkg::ACK_BYTE;
    end else begin
      push_byte(q, ubce_pkg::ACK_BYTE);
    end
  endtask

  // Advance the protocol predictor by one received byte.
  task automatic predict_boot_reply(input logic [7:0] d);
    ubce_pkg::result_t q[$];
    logic [31:0] w;
    logic [1:0] lane;
    case (phase_q)
      PH_UNSYNCED: if (d == ubce_pkg::SYNC_BYTE) begin
        push_byte(q, ubce_pkg::ACK_BYTE);
        phase_q = PH_IDLE;
      end
      PH_COMPL: begin
        phase_q = PH_IDLE;
        if (d != ~cmd_q) push_byte(q, ubce_pkg::NACK_BYTE);
        else case (cmd_q)
          ubce_pkg::CMD_GET: begin
            push_byte(q, ubce_pkg::ACK_BYTE); push_byte(q, 8'd6); push_byte(q, version_q);
            push_byte(q, ubce_pkg::CMD_GET); push_byte(q, ubce_pkg::CMD_GETID);
            push_byte(q, ubce_pkg::CMD_RDMEM); push_byte(q, ubce_pkg::CMD_GO);
            push_byte(q, ubce_pkg::CMD_WRMEM); push_byte(q, ubce_pkg::CMD_ERASE);
            push_byte(q, ubce_pkg::ACK_BYTE);
          end
          ubce_pkg::CMD_GETID: begin
            push_byte(q, ubce_pkg::ACK_BYTE); push_byte(q, 8'd1);
            push_byte(q, chip_id_q[15:8]); push_byte(q, chip_id_q[7:0]);
            push_byte(q, ubce_pkg::ACK_BYTE);
          end
          ubce_pkg::CMD_RDMEM, ubce_pkg::CMD_GO, ubce_pkg::CMD_WRMEM: begin
            push_byte(q, ubce_pkg::ACK_BYTE); addr_q = '0; count_q = '0; phase_q = PH_ADDR;
          end
          ubce_pkg::CMD_ERASE: begin
            push_byte(q, ubce_pkg::ACK_BYTE); addr_q = '0; count_q = '0;
            phase_q = PH_ERASE_N;
          end
          default: push_byte(q, ubce_pkg::NACK_BYTE);
        endcase
      end
      PH_ADDR: begin
        addr_q = {addr_q[23:0], d};
        count_q++;
        if (count_q >= 4) phase_q = PH_ADDR_CHK;
      end
      PH_ADDR_CHK: begin
        phase_q = PH_IDLE;
        if (cmd_q == ubce_pkg::CMD_WRMEM) begin
          if ((addr_q[7:0] ^ addr_q[15:8] ^ addr_q[23:16] ^ addr_q[31:24]) != d)
            push_byte(q, ubce_pkg::NACK_BYTE);
          else begin
            push_byte(q, ubce_pkg::ACK_BYTE); phase_q = PH_LEN;
          end
        end else if (cmd_q == ubce_pkg::CMD_RDMEM) begin
          push_byte(q, ubce_pkg::ACK_BYTE); phase_q = PH_LEN;
        end else begin
          push_byte(q, ubce_pkg::ACK_BYTE);
          q.push_back(mk(1'b0, '0, ubce_pkg::OP_JUMP, addr_q, '0, 1'b0));
        end
      end
      PH_LEN: begin
        len_m1_q = d; xor_q = d; count_q = '0;
        phase_q = (cmd_q == ubce_pkg::CMD_WRMEM) ? PH_DATA : PH_READ_CHK;
      end
      PH_READ_CHK: begin
        push_byte(q, ubce_pkg::ACK_BYTE);
        q.push_back(mk(1'b0, '0, ubce_pkg::OP_READ, addr_q, 32'(len_m1_q) + 1, 1'b0));
        phase_q = PH_IDLE;
      end
      PH_DATA: begin
        w = 32'(count_q >> 2);
        lane = count_q[1:0];
        if (w < NWORDS) begin
          if (lane == 0) words_q[w] = 32'(d);
          else words_q[w][8*lane +: 8] = d;
        end
        xor_q ^= d;
        count_q++;
        if (count_q >= 9'(len_m1_q) + 9'd1) phase_q = PH_DATA_CHK;
      end
      PH_DATA_CHK: begin
        finish_write(q, d); phase_q = PH_IDLE;
      end
      PH_ERASE_N: begin
        addr_q = {16'h0, addr_q[7:0], d};
        count_q++;
        if (count_q >= 2) phase_q = PH_ERASE_CHK;
      end
      PH_ERASE_CHK: begin
        if (addr_q == 32'hFFFF) begin
          q.push_back(mk(1'b0, '0, ubce_pkg::OP_ERASE, flash_base_q + 32'(boot_size_q),
                         '0, 1'b0));
          push_byte(q, ubce_pkg::ACK_BYTE);
        end else push_byte(q, ubce_pkg::NACK_BYTE);
        phase_q = PH_IDLE;
      end
      default: begin
        cmd_q = d;
        phase_q = (d != ubce_pkg::CMD_NONE) ? PH_COMPL : PH_IDLE;
      end
    endcase
    if (q.size() > 0) q[q.size()-1].last = 1'b1;
    pred_count = q.size();
    if (q.size() > 0) pred_first = q[0].send_byte;
    foreach (q[i]) reply_queue.push_back(q[i]);
  endtask

  // Send one byte with valid/ready; the predictor runs at acceptance.
  // Valid stays high on return; the next send or a drain takes it down.
  task automatic send_item(input logic [7:0] b);
    while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_boot_reply(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (reply_queue.size() != 0 && !timed_out) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  // Drives one register write; the caller drops the write enable afterwards.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    case (idx)
      ubce_pkg::CFG_FLASH_BASE: flash_base_q = val;
      ubce_pkg::CFG_RAM_BASE: ram_base_q = val;
      ubce_pkg::CFG_BOOT_SIZE: boot_size_q = val[20:0];
      ubce_pkg::CFG_CHIP_ID: chip_id_q = val[15:0];
      ubce_pkg::CFG_VERSION: version_q = val[7:0];
      default: ;
    endcase
  endtask

  // Write with address checksum; the data checksum is inverted when corrupt is set.
  task automatic send_write(input logic [31:0] a, input int nbytes, input bit corrupt);
    logic [7:0] x;
    send_item(ubce_pkg::CMD_WRMEM); send_item(~ubce_pkg::CMD_WRMEM);
    for (int i = 3; i >= 0; i--) send_item(a[8*i +: 8]);
    send_item(a[7:0] ^ a[15:8] ^ a[23:16] ^ a[31:24]);
    if (phase_q != PH_LEN) return;
    x = 8'(nbytes - 1);
    send_item(x);
    for (int i = 0; i < nbytes; i++) begin
      logic [7:0] b;
      b = 8'($urandom);
      x ^= b;
      send_item(b);
    end
    send_item(corrupt ? ~x : x);
  endtask

  task automatic send_addr_cmd(input logic [7:0] c, input logic [31:0] a);
    send_item(c); send_item(~c);
    for (int i = 3; i >= 0; i--) send_item(a[8*i +: 8]);
    send_item(8'($urandom));
  endtask

  // Random well-formed commands with random content, plus noise.
  task automatic random_command();
    logic [31:0] a;
    int n;
    n = 4 * $urandom_range(1, 2);
    a = $urandom_range(3) == 0 ? $urandom : flash_base_q + 32'($urandom_range(16383) & ~3);
    case ($urandom_range(9))
      0: begin send_item(ubce_pkg::CMD_GET); send_item(~ubce_pkg::CMD_GET); end
      1: begin send_item(ubce_pkg::CMD_GETID); send_item(~ubce_pkg::CMD_GETID); end
      2: begin send_addr_cmd(ubce_pkg::CMD_RDMEM, $urandom); send_item(8'($urandom));
               send_item(8'($urandom)); end
      3: send_addr_cmd(ubce_pkg::CMD_GO, $urandom);
      4, 5: send_write(a, $urandom_range(7) == 0 ? $urandom_range(1, 5) : n,
                       $urandom_range(7) == 0);
      6: begin send_item(ubce_pkg::CMD_ERASE); send_item(~ubce_pkg::CMD_ERASE);
           if ($urandom_range(1)) begin send_item(8'hFF); send_item(8'hFF); end
           else begin send_item(8'($urandom)); send_item(8'($urandom)); end
           send_item(8'($urandom)); end
      7: begin send_item(8'($urandom)); send_item(8'($urandom)); end
      8: send_item(ubce_pkg::CMD_NONE);
      default: begin send_item(ubce_pkg::CMD_WRMEM); send_item(~ubce_pkg::CMD_WRMEM);
           for (int i = 0; i < 5; i++) send_item(8'($urandom)); end
    endcase
  endtask

  // Receiver: random stalls, or a long counted hold-off when requested.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else out_ready <= !($urandom_range(99) < receiver_idle_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    ubce_pkg::result_t got, exp_r;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_send_valid, out_send_byte, out_mem_op, out_mem_addr,
              out_mem_data, out_to_flash, out_last};
      results_seen++;
      if (reply_queue.size() == 0) begin
        unexpected++;
        if (mismatches + unexpected <= 10) $display("Unexpected result %p", got);
      end else begin
        exp_r = reply_queue.pop_front();
        if (got !== exp_r) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("Mismatch: expected %p, got %p", exp_r, got);
        end
      end
    end
  end

  // Watchdog on cycles with no accepted item on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("Watchdog expired with %0d results outstanding", reply_queue.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Directed rows: byte plus, where obvious, the expected first reply byte.
  typedef struct {
    logic [7:0] rx;
    bit         has_exp;
    logic [7:0] exp_byte;
  } stim_row_t;

  stim_row_t directed_rows [22] = '{
    '{8'h00, 0, 8'h00}, '{8'hFF, 0, 8'h00},
    '{ubce_pkg::SYNC_BYTE, 1, ubce_pkg::ACK_BYTE},
    '{ubce_pkg::SYNC_BYTE, 0, 8'h00}, '{8'h00, 1, ubce_pkg::NACK_BYTE},
    '{ubce_pkg::CMD_NONE, 0, 8'h00}, '{ubce_pkg::CMD_GET, 0, 8'h00},
    '{8'hFF, 1, ubce_pkg::ACK_BYTE},
    '{ubce_pkg::CMD_GETID, 0, 8'h00}, '{8'hFD, 1, ubce_pkg::ACK_BYTE},
    '{8'h55, 0, 8'h00}, '{8'hAA, 1, ubce_pkg::NACK_BYTE},
    '{ubce_pkg::CMD_ERASE, 0, 8'h00}, '{8'hBB, 1, ubce_pkg::ACK_BYTE},
    '{8'hFF, 0, 8'h00}, '{8'hFF, 0, 8'h00}, '{8'h00, 0, 8'h00},
    '{ubce_pkg::CMD_ERASE, 0, 8'h00}, '{8'hBB, 0, 8'h00}, '{8'h00, 0, 8'h00},
    '{8'h00, 0, 8'h00}, '{8'h00, 1, ubce_pkg::NACK_BYTE}
  };

  initial begin
    flash_base_q = 32'h0800_0000; ram_base_q = 32'h2000_0000; boot_size_q = 21'd10240;
    chip_id_q = 16'h0414; version_q = 8'h30;
    phase_q = PH_UNSYNCED; cmd_q = '0; addr_q = '0; count_q = '0;
    len_m1_q = '0; xor_q = '0;
    foreach (words_q[i]) words_q[i] = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part with the reset configuration.
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].rx);
      if (directed_rows[i].has_exp &&
          (pred_count == 0 || pred_first != directed_rows[i].exp_byte)) begin
        mismatches++;
        $display("Directed row %0d: reply differs from table", i);
      end
    end
    send_write(32'h0800_0000, 4, 0);     // entirely inside boot region
    send_write(32'h0800_27FC, 8, 0);     // straddles end of boot region
    send_write(32'h2000_0100, 2, 0);     // length not a multiple of four
    send_write(32'h2000_0100, 4, 1);     // bad data checksum
    send_addr_cmd(ubce_pkg::CMD_GO, 32'hFFFF_FFFF);
    send_addr_cmd(ubce_pkg::CMD_RDMEM, 32'h0); send_item(8'hFF); send_item(8'h00);
    wait_drained();

    // Three random phases under different idling and configuration.
    for (int ph = 0; ph < 3; ph++) begin
      sender_idle_pct = ph == 0 ? 6 : ph == 1 ? 87 : 0;
      receiver_idle_pct = ph == 0 ? 87 : ph == 1 ? 6 : 0;
      case (ph)
        0: begin
          write_reg(ubce_pkg::CFG_FLASH_BASE, 32'hFFFF_F000);
          write_reg(ubce_pkg::CFG_RAM_BASE, 32'hFFFF_FFFF);
          write_reg(ubce_pkg::CFG_BOOT_SIZE, 32'd1048576);
          write_reg(ubce_pkg::CFG_CHIP_ID, 32'hFFFF);
          write_reg(ubce_pkg::CFG_VERSION, 32'hFF);
        end
        1: begin
          write_reg(ubce_pkg::CFG_FLASH_BASE, 32'h0);
          write_reg(ubce_pkg::CFG_RAM_BASE, 32'h0001_0000);
          write_reg(ubce_pkg::CFG_BOOT_SIZE, 32'd0);
          write_reg(ubce_pkg::CFG_CHIP_ID, 32'h0);
          write_reg(ubce_pkg::CFG_VERSION, 32'h0);
        end
        default: begin
          write_reg(ubce_pkg::CFG_FLASH_BASE, $urandom & ~32'h3);
          write_reg(ubce_pkg::CFG_RAM_BASE, $urandom);
          write_reg(ubce_pkg::CFG_BOOT_SIZE, $urandom_range(1048576));
          write_reg(ubce_pkg::CFG_CHIP_ID, $urandom);
          write_reg(ubce_pkg::CFG_VERSION, $urandom);
        end
      endcase
      cfg_we <= 1'b0;
      random_command();
      if (ph == 2) begin
        // Long receiver hold-off while bytes keep coming, then a full drain.
        while (phase_q != PH_IDLE) send_item(ubce_pkg::CMD_NONE);
        hold_off_cycles = 400;
        for (int c = 0; c < 4; c++) send_item(c[0] ? ~ubce_pkg::CMD_GET : ubce_pkg::CMD_GET);
        wait_drained();
      end
      random_command();
      wait_drained();
    end

    $display("Sent %0d bytes, checked %0d results over three configurations.",
             bytes_sent, results_seen);
    $display("Covered all commands, protected writes, bad checksums and idling mixes.");
    if (mismatches == 0 && unexpected == 0 && reply_queue.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
